/* rtl/core/gbq_pkg.sv */
package gbq_pkg;

	localparam int FIELD_W = 24;
	localparam int NCOEF   = 5;
	localparam int IDX_W   = 3;
	localparam int STEP_W  = 3;

	typedef logic [STEP_W-1:0] step_t;
	typedef logic [NCOEF-1:0][FIELD_W-1:0] coef_arr_t;

	localparam step_t STEP_WAIT  = 3'd0;
	localparam step_t STEP_FIRST = 3'd1;
	localparam step_t STEP_LAST  = 3'd5;

	// Register indexes double as the coefficient select of the multiplier.
	typedef enum logic [IDX_W-1:0] {
		REG_B0 = 3'd0,
		REG_B1 = 3'd1,
		REG_B2 = 3'd2,
		REG_A1 = 3'd3,
		REG_A2 = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		OPND_PORT = 2'd0,
		OPND_X    = 2'd1,
		OPND_Y    = 2'd2
	} opnd_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_SUB  = 2'd2
	} acc_op_t;

	typedef enum logic [1:0] {
		JMP_NEXT     = 2'd0,
		JMP_WAIT_IN  = 2'd1,
		JMP_WAIT_OUT = 2'd2
	} jmp_t;

	typedef struct packed {
		reg_idx_t  mul_a;
		opnd_sel_t mul_b;
		logic      ld_prod;
		logic      ld_x;
		logic      ld_y;
		acc_op_t   acc_op;
		logic      ld_nz1;
		logic      finish;
		logic      clr;
	} dp_ctrl_t;

	typedef struct packed {
		dp_ctrl_t dp;
		jmp_t     jmp;
		step_t    target;
	} ucode_t;

	// Control store: one word per step.
	function automatic ucode_t gbq_ucode(step_t step);
		ucode_t w;
		w = '0;
		unique case (step)
			3'd0: begin
				w.dp.mul_a   = REG_B0;
				w.dp.mul_b   = OPND_PORT;
				w.dp.ld_prod = 1'b1;
				w.dp.ld_x    = 1'b1;
				w.jmp        = JMP_WAIT_IN;
				w.target     = STEP_FIRST;
			end
			3'd1: begin
				w.dp.mul_a   = REG_B1;
				w.dp.mul_b   = OPND_X;
				w.dp.ld_prod = 1'b1;
				w.dp.ld_y    = 1'b1;
				w.jmp        = JMP_NEXT;
			end
			3'd2: begin
				w.dp.mul_a   = REG_A1;
				w.dp.mul_b   = OPND_Y;
				w.dp.ld_prod = 1'b1;
				w.dp.acc_op  = ACC_LOAD;
				w.jmp        = JMP_NEXT;
			end
			3'd3: begin
				w.dp.mul_a   = REG_B2;
				w.dp.mul_b   = OPND_X;
				w.dp.ld_prod = 1'b1;
				w.dp.acc_op  = ACC_SUB;
				w.jmp        = JMP_NEXT;
			end
			3'd4: begin
				w.dp.mul_a   = REG_A2;
				w.dp.mul_b   = OPND_Y;
				w.dp.ld_prod = 1'b1;
				w.dp.acc_op  = ACC_LOAD;
				w.dp.ld_nz1  = 1'b1;
				w.jmp        = JMP_NEXT;
			end
			3'd5: begin
				w.dp.finish = 1'b1;
				w.jmp       = JMP_WAIT_OUT;
				w.target    = STEP_WAIT;
			end
			default: begin
				w.jmp    = JMP_WAIT_OUT;
				w.target = STEP_WAIT;
			end
		endcase
		return w;
	endfunction

endpackage

/* rtl/core/gbq_datapath.sv */
module gbq_datapath import gbq_pkg::*; #(
	parameter int FRAC_BITS = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_ctrl_t                  ctrl,
	input  coef_arr_t                 coef,
	input  logic signed [FIELD_W-1:0] sample_in,
	output logic signed [FIELD_W-1:0] res_sample,
	output logic                      res_trip
);

	localparam int D_W   = FRAC_BITS + 6;
	localparam int P0_W  = 2 * FIELD_W;
	localparam int Y_W   = ((P0_W - FRAC_BITS) > D_W ? (P0_W - FRAC_BITS) : D_W) + 1;
	localparam int MUL_W = FIELD_W + Y_W;
	localparam int ACC_W = MUL_W + 1;
	localparam int NZ_W  = ((ACC_W - FRAC_BITS) > D_W ? (ACC_W - FRAC_BITS) : D_W) + 1;

	localparam longint GUARD  = longint'(16) << FRAC_BITS;
	localparam longint LIM    = longint'(8) << FRAC_BITS;
	localparam longint FMAX   = (longint'(1) << (FIELD_W - 1)) - 1;
	localparam longint FMIN   = -(longint'(1) << (FIELD_W - 1));
	localparam longint SAT_HI = (LIM < FMAX) ? LIM : FMAX;
	localparam longint SAT_LO = (-LIM > FMIN) ? -LIM : FMIN;

	localparam logic signed [NZ_W-1:0] GUARD_P = NZ_W'(GUARD);
	localparam logic signed [NZ_W-1:0] GUARD_N = NZ_W'(-GUARD);
	localparam logic signed [Y_W-1:0]  Y_HI    = Y_W'(SAT_HI);
	localparam logic signed [Y_W-1:0]  Y_LO    = Y_W'(SAT_LO);

	logic signed [FIELD_W-1:0] x_q;
	logic signed [MUL_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [Y_W-1:0]     y_q;
	logic signed [NZ_W-1:0]    nz1_q;
	logic signed [D_W-1:0]     d1_q;
	logic signed [D_W-1:0]     d2_q;

	logic signed [FIELD_W-1:0] a_opnd;
	logic signed [Y_W-1:0]     b_opnd;
	logic signed [MUL_W-1:0]   mul_res;
	logic signed [Y_W-1:0]     y_next;
	logic signed [NZ_W-1:0]    nz1_next;
	logic signed [ACC_W-1:0]   diff;
	logic signed [NZ_W-1:0]    nz2;
	logic signed [Y_W-1:0]     y_sat;

	always_comb begin
		unique case (ctrl.mul_a)
			REG_B0:  a_opnd = signed'(coef[REG_B0]);
			REG_B1:  a_opnd = signed'(coef[REG_B1]);
			REG_B2:  a_opnd = signed'(coef[REG_B2]);
			REG_A1:  a_opnd = signed'(coef[REG_A1]);
			REG_A2:  a_opnd = signed'(coef[REG_A2]);
			default: a_opnd = signed'(coef[REG_B0]);
		endcase
		unique case (ctrl.mul_b)
			OPND_PORT: b_opnd = Y_W'(sample_in);
			OPND_X:    b_opnd = Y_W'(x_q);
			OPND_Y:    b_opnd = y_q;
			default:   b_opnd = y_q;
		endcase
	end

	assign mul_res = a_opnd * b_opnd;

	// Arithmetic shift right is the floor to FRAC_BITS fractional bits.
	assign y_next   = Y_W'(prod_q >>> FRAC_BITS) + Y_W'(d1_q);
	assign nz1_next = NZ_W'(acc_q >>> FRAC_BITS) + NZ_W'(d2_q);
	assign diff     = acc_q - ACC_W'(prod_q);
	assign nz2      = NZ_W'(diff >>> FRAC_BITS);

	assign res_trip = (nz1_q > GUARD_P) || (nz1_q < GUARD_N) ||
		(nz2 > GUARD_P) || (nz2 < GUARD_N);

	always_comb begin
		if (y_q > Y_HI) begin
			y_sat = Y_HI;
		end else if (y_q < Y_LO) begin
			y_sat = Y_LO;
		end else begin
			y_sat = y_q;
		end
	end

	assign res_sample = res_trip ? '0 : FIELD_W'(y_sat);

	always_ff @(posedge clk) begin
		if (ctrl.ld_prod) begin
			prod_q <= mul_res;
		end
		if (ctrl.ld_x) begin
			x_q <= sample_in;
		end
		if (ctrl.ld_y) begin
			y_q <= y_next;
		end
		if (ctrl.ld_nz1) begin
			nz1_q <= nz1_next;
		end
		unique case (ctrl.acc_op)
			ACC_LOAD: acc_q <= ACC_W'(prod_q);
			ACC_SUB:  acc_q <= diff;
			default:  acc_q <= acc_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
		end else begin
			priority if (ctrl.clr) begin
				d1_q <= '0;
				d2_q <= '0;
			end else if (ctrl.finish) begin
				if (res_trip) begin
					d1_q <= '0;
					d2_q <= '0;
				end else begin
					d1_q <= D_W'(nz1_q);
					d2_q <= D_W'(nz2);
				end
			end
		end
	end

endmodule

/* rtl/core/guarded_biquad_section_top.sv */
// Guarded biquad section: one transposed direct form II second-order filter
// in signed fixed point (Q4.20 at the default FRAC_BITS).
// Input channel req_valid/req_ready carries one item, sample_in. Result
// channel rsp_valid/rsp_ready returns one item per input: sample_out,
// saturated to [-8.0, 8.0 - 2^-20], and guard_tripped, set when either new
// delay exceeded magnitude 16.0 (delays then clear and sample_out is 0).
// Each accepted item runs through the steps of the six-step control store;
// its five products go one after another through the single 24 x Y_W
// multiplier, and the last step loads the output register. No new item is
// taken until the program is back at its wait step.
// The output register parts the two sides: the next item is accepted while
// a result still waits. If the receiver stalls, the last step holds until
// the output register is free, and no further item is accepted meanwhile.
// Coefficients are written through cfg_we/cfg_index/cfg_data, by the user
// only while idle; the block does not enforce this. Any write to a valid
// index clears both delays, other indexes are ignored. Reset loads b0 =
// 1.0 (bypass), the others 0, clears delays, empties the output register.
module guarded_biquad_section_top import gbq_pkg::*; #(
	parameter int FRAC_BITS = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  logic signed [FIELD_W-1:0] sample_in,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output logic signed [FIELD_W-1:0] sample_out,
	output logic                      guard_tripped,
	input  logic                      cfg_we,
	input  logic [IDX_W-1:0]          cfg_index,
	input  logic [FIELD_W-1:0]        cfg_data
);

	localparam logic [FIELD_W-1:0] B0_RESET = FIELD_W'(longint'(1) << FRAC_BITS);

	step_t     step_q;
	coef_arr_t coef_q;
	ucode_t    uc;
	dp_ctrl_t  ctrl;
	logic      fire;
	logic      slot_free;
	logic      advance;
	logic      cfg_hit;
	logic signed [FIELD_W-1:0] res_sample;
	logic      res_trip;

	// Fetch the control word for the current step.
	assign uc = gbq_ucode(step_q);

	assign req_ready = (uc.jmp == JMP_WAIT_IN);
	assign fire      = req_valid && req_ready;
	assign slot_free = !rsp_valid || rsp_ready;
	assign cfg_hit   = cfg_we && (cfg_index <= REG_A2);

	always_comb begin
		unique case (uc.jmp)
			JMP_NEXT:     advance = 1'b1;
			JMP_WAIT_IN:  advance = fire;
			JMP_WAIT_OUT: advance = slot_free;
			default:      advance = 1'b0;
		endcase
	end

	// Drop every action of a step that does not advance; the datapath holds.
	always_comb begin
		ctrl     = advance ? uc.dp : dp_ctrl_t'('0);
		ctrl.clr = cfg_hit;
	end

	// Step counter: advance in order, or jump to the target of a wait step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else if (advance) begin
			if (uc.jmp == JMP_NEXT) begin
				step_q <= step_q + STEP_W'(1);
			end else begin
				step_q <= uc.target;
			end
		end
	end

	// Coefficient registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[REG_B0] <= B0_RESET;
			coef_q[REG_B1] <= '0;
			coef_q[REG_B2] <= '0;
			coef_q[REG_A1] <= '0;
			coef_q[REG_A2] <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_B0:  coef_q[REG_B0] <= cfg_data;
				REG_B1:  coef_q[REG_B1] <= cfg_data;
				REG_B2:  coef_q[REG_B2] <= cfg_data;
				REG_A1:  coef_q[REG_A1] <= cfg_data;
				REG_A2:  coef_q[REG_A2] <= cfg_data;
				default: coef_q <= coef_q;
			endcase
		end
	end

	gbq_datapath #(
		.FRAC_BITS(FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.coef      (coef_q),
		.sample_in (sample_in),
		.res_sample(res_sample),
		.res_trip  (res_trip)
	);

	// Output register: load on the last step, empty when the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (uc.dp.finish && advance) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (uc.dp.finish && advance) begin
			sample_out    <= res_sample;
			guard_tripped <= res_trip;
		end
	end

	// An accepted item starts the program at its first compute step.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (step_q == STEP_FIRST))
		else $error("accepted item did not start the program");

	// Completing the last step always leaves a result on offer.
	assert property (@(posedge clk) disable iff (!arst_n)
		(uc.dp.finish && advance) |=> rsp_valid)
		else $error("finished item not presented");

	// A tripped guard forces the sample to zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && guard_tripped) |-> (sample_out == '0))
		else $error("guard tripped with non-zero sample");

endmodule

/* tb/guarded_biquad_section_top_tb.sv */
module guarded_biquad_section_top_tb;

	import gbq_pkg::*;

	// Fixed-point format of the section under test (Q4.20).
	localparam int     FRAC      = 20;
	localparam longint ONE       = longint'(1) << FRAC;
	localparam longint GUARD_LIM = 16 * ONE;
	localparam longint SAT_LIM   = 8 * ONE;
	localparam longint FIELD_MAX = (longint'(1) << (FIELD_W - 1)) - 1;
	localparam longint FIELD_MIN = -(longint'(1) << (FIELD_W - 1));

	// The last step may still be finishing after the final result; allow for it.
	localparam int SETTLE_CYCLES = 8;
	// Slowest run: about 500 items plus sender gaps, receiver stalls and
	// settling. Take it many times over.
	localparam int CYCLE_LIMIT   = 400000;

	// How the random phases pick their coefficients.
	typedef enum int {
		COEF_SMALL,
		COEF_FULL,
		COEF_EXTREME
	} coef_style_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] sample_out;
		logic                      guard_tripped;
	} biquad_out_t;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      req_valid;
	logic                      req_ready;
	logic signed [FIELD_W-1:0] sample_in;
	logic                      rsp_valid;
	logic                      rsp_ready = 1'b0;
	logic signed [FIELD_W-1:0] sample_out;
	logic                      guard_tripped;
	logic                      cfg_we;
	logic [IDX_W-1:0]          cfg_index;
	logic [FIELD_W-1:0]        cfg_data;

	// Shadow copy of the filter: coefficients and both delays, in Q.20.
	longint tap_coef [NCOEF];
	longint z1;
	longint z2;

	// Filtered samples predicted but not yet seen on the result channel.
	biquad_out_t biquad_out_q [$];

	bit gaps_on   = 1'b1;
	int rsp_stall = 0;
	int mismatches = 0;

	always #4 clk = ~clk;

	guarded_biquad_section_top #(
		.FRAC_BITS(FRAC)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_ready    (req_ready),
		.sample_in    (sample_in),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.sample_out   (sample_out),
		.guard_tripped(guard_tripped),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// One step of the transposed direct form II section. Each sum is floored
	// to 20 fractional bits (arithmetic shift of a signed value); the y fed
	// back is the unsaturated one. A new delay beyond 16.0 in magnitude
	// clears both delays and forces the output to zero.
	function automatic biquad_out_t biquad_step(logic signed [FIELD_W-1:0] x);
		longint      xv;
		longint      yv;
		longint      nz1;
		longint      nz2;
		biquad_out_t r;
		xv  = x;
		yv  = ((tap_coef[REG_B0] * xv) >>> FRAC) + z1;
		nz1 = ((tap_coef[REG_B1] * xv - tap_coef[REG_A1] * yv) >>> FRAC) + z2;
		nz2 = (tap_coef[REG_B2] * xv - tap_coef[REG_A2] * yv) >>> FRAC;
		if (nz1 > GUARD_LIM || nz1 < -GUARD_LIM || nz2 > GUARD_LIM || nz2 < -GUARD_LIM) begin
			z1 = 0;
			z2 = 0;
			r.sample_out    = '0;
			r.guard_tripped = 1'b1;
		end else begin
			z1 = nz1;
			z2 = nz2;
			// Clamp to plus or minus 8.0, then to the field; +8.0 itself
			// does not fit in 24 bits.
			if (yv > SAT_LIM)
				yv = SAT_LIM;
			if (yv < -SAT_LIM)
				yv = -SAT_LIM;
			if (yv > FIELD_MAX)
				yv = FIELD_MAX;
			if (yv < FIELD_MIN)
				yv = FIELD_MIN;
			r.sample_out    = yv[FIELD_W-1:0];
			r.guard_tripped = 1'b0;
		end
		return r;
	endfunction

	// Write one register, then mirror it: a valid index also clears the delays.
	task automatic write_reg(logic [IDX_W-1:0] idx, logic [FIELD_W-1:0] value);
		logic signed [FIELD_W-1:0] sv;
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx < NCOEF) begin
			sv = value;
			tap_coef[idx] = sv;
			z1 = 0;
			z2 = 0;
		end
	endtask

	// Offer one sample and hold it until taken; predict its result on acceptance.
	// Valid is left high afterwards, so a following item never lowers and
	// raises it in the same step.
	task automatic send_sample(logic signed [FIELD_W-1:0] x);
		int unsigned gap;
		gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
		@(negedge clk);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		sample_in <= x;
		do
			@(posedge clk);
		while (!req_ready);
		biquad_out_q.push_back(biquad_step(x));
	endtask

	// Drop valid, wait for every outstanding result, then let the block go quiet.
	task automatic settle();
		@(negedge clk);
		req_valid <= 1'b0;
		while (biquad_out_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [FIELD_W-1:0] rand_sample();
		longint v;
		case ($urandom_range(0, 3))
			0, 1: v = longint'($urandom_range(0, 2 * ONE)) - ONE;
			2: v = $urandom;
			default: begin
				case ($urandom_range(0, 4))
					0: v = FIELD_MAX;
					1: v = FIELD_MIN;
					2: v = 0;
					3: v = 1;
					default: v = -1;
				endcase
			end
		endcase
		return v[FIELD_W-1:0];
	endfunction

	function automatic logic [FIELD_W-1:0] rand_coef(coef_style_t style, longint span);
		longint v;
		case (style)
			COEF_SMALL: v = longint'($urandom_range(0, 2 * span)) - span;
			COEF_FULL: v = $urandom;
			default: begin
				case ($urandom_range(0, 4))
					0: v = FIELD_MAX;
					1: v = FIELD_MIN;
					2: v = 0;
					3: v = ONE;
					default: v = -ONE;
				endcase
			end
		endcase
		return v[FIELD_W-1:0];
	endfunction

	// Reset state is pure bypass: b0 = 1.0, the rest zero, so y equals x.
	task automatic test_bypass_after_reset();
		send_sample(FIELD_W'(0));
		send_sample(FIELD_W'(FIELD_MAX));
		send_sample(FIELD_W'(FIELD_MIN));
		send_sample(FIELD_W'(1));
		send_sample(FIELD_W'(-1));
		send_sample(FIELD_W'(ONE));
		send_sample(FIELD_W'(-ONE));
	endtask

	// Near-8.0 gain on full-scale input drives y to about 64; clamp both ways.
	task automatic test_output_saturation();
		settle();
		write_reg(REG_B0, FIELD_W'(FIELD_MAX));
		send_sample(FIELD_W'(FIELD_MAX));
		send_sample(FIELD_W'(FIELD_MIN));
		send_sample(FIELD_W'(0));
	endtask

	// b2 = -8.0 with x = -2.0 gives exactly +16.0 in the second delay: no trip.
	// One LSB further trips. Then the same on the negative side, and a trip
	// through the first delay via the a1 feedback.
	task automatic test_guard_boundary();
		settle();
		write_reg(REG_B0, FIELD_W'(ONE));
		write_reg(REG_B2, FIELD_W'(FIELD_MIN));
		send_sample(FIELD_W'(-2 * ONE));
		send_sample(FIELD_W'(-2 * ONE - 1));
		send_sample(FIELD_W'(2 * ONE));
		send_sample(FIELD_W'(2 * ONE + 1));
		settle();
		write_reg(REG_B2, FIELD_W'(0));
		write_reg(REG_B0, FIELD_W'(FIELD_MAX));
		write_reg(REG_A1, FIELD_W'(FIELD_MIN));
		send_sample(FIELD_W'(FIELD_MAX));
		send_sample(FIELD_W'(0));
	endtask

	// Build up both delays, rewrite a coefficient with its own value and
	// confirm the next output no longer carries the old delay.
	task automatic test_coef_write_clears();
		settle();
		write_reg(REG_A1, FIELD_W'(0));
		write_reg(REG_B0, FIELD_W'(ONE));
		write_reg(REG_B1, FIELD_W'(ONE));
		write_reg(REG_B2, FIELD_W'(ONE));
		write_reg(REG_A2, FIELD_W'(ONE / 4));
		send_sample(FIELD_W'(ONE));
		settle();
		write_reg(REG_B2, FIELD_W'(ONE));
		send_sample(FIELD_W'(0));
	endtask

	// Writes to indexes past the last coefficient are dropped; delays survive.
	task automatic test_unused_index();
		settle();
		send_sample(FIELD_W'(ONE));
		settle();
		for (int i = NCOEF; i < (1 << IDX_W); i++)
			write_reg(IDX_W'(i), FIELD_W'(FIELD_MAX));
		send_sample(FIELD_W'(0));
	endtask

	// Phases of random coefficient sets: half modest filters so the delays
	// evolve over many samples, with full-range and extreme sets mixed in.
	task automatic test_random_filters();
		coef_style_t style;
		for (int phase = 0; phase < 10; phase++) begin
			settle();
			case (phase % 4)
				0, 3: style = COEF_SMALL;
				1: style = COEF_FULL;
				default: style = COEF_EXTREME;
			endcase
			write_reg(REG_B0, rand_coef(style, ONE));
			write_reg(REG_B1, rand_coef(style, ONE));
			write_reg(REG_B2, rand_coef(style, ONE));
			write_reg(REG_A1, rand_coef(style, 2 * ONE));
			write_reg(REG_A2, rand_coef(style, ONE));
			if ($urandom_range(0, 2) == 0)
				write_reg(IDX_W'($urandom_range(NCOEF, (1 << IDX_W) - 1)),
					FIELD_W'($urandom));
			for (int n = 0; n < 40; n++)
				send_sample(rand_sample());
		end
	endtask

	// Back-to-back traffic with no gaps or stalls on either side.
	task automatic test_full_rate();
		settle();
		gaps_on = 1'b0;
		write_reg(REG_B0, rand_coef(COEF_SMALL, ONE));
		write_reg(REG_B1, rand_coef(COEF_SMALL, ONE));
		write_reg(REG_B2, rand_coef(COEF_SMALL, ONE));
		write_reg(REG_A1, rand_coef(COEF_SMALL, 2 * ONE));
		write_reg(REG_A2, rand_coef(COEF_SMALL, ONE));
		for (int n = 0; n < 50; n++)
			send_sample(rand_sample());
	endtask

	// Receiver: stall in random bursts while gaps are enabled.
	always @(negedge clk) begin
		if (rsp_stall != 0) begin
			rsp_ready <= 1'b0;
			rsp_stall--;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			rsp_ready <= 1'b0;
			rsp_stall = $urandom_range(1, 5) - 1;
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// Compare each result taken against the oldest prediction.
	always @(posedge clk) begin : check_results
		biquad_out_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (biquad_out_q.size() == 0) begin
				$error("result with no sample outstanding: sample_out %0d guard_tripped %0b",
					sample_out, guard_tripped);
				mismatches++;
			end else begin
				want = biquad_out_q.pop_front();
				if (sample_out !== want.sample_out) begin
					$error("sample_out: expected %0d, got %0d", want.sample_out, sample_out);
					mismatches++;
				end
				if (guard_tripped !== want.guard_tripped) begin
					$error("guard_tripped: expected %0b, got %0b", want.guard_tripped,
						guard_tripped);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: end the run if the handshakes stop moving.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("guarded_biquad_section_top verification failed");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		req_valid = 1'b0;
		sample_in = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		tap_coef[REG_B0] = ONE;
		tap_coef[REG_B1] = 0;
		tap_coef[REG_B2] = 0;
		tap_coef[REG_A1] = 0;
		tap_coef[REG_A2] = 0;
		z1 = 0;
		z2 = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_bypass_after_reset();
		test_output_saturation();
		test_guard_boundary();
		test_coef_write_clears();
		test_unused_index();
		test_random_filters();
		test_full_rate();
		settle();

		if (mismatches == 0) begin
			$display("guarded_biquad_section_top verification clean");
		end else begin
			$display("guarded_biquad_section_top verification failed");
		end
		$finish;
	end

endmodule
